// ===== design/modular_exponentiation_defines.svh =====
// Assertion macros shared by the modular exponentiation design files.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MEXP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mexp_pkg.sv =====
// Types, constants and the microcode program of the modular exponentiation block.
package mexp_pkg;

	// Width of the stream and configuration fields.
	localparam int DATA_BITS = 32;
	// Operand width used by the arithmetic (8 to 32); wider field bits are dropped.
	localparam int OPERAND_BITS = 32;
	localparam int CNT_BITS = $clog2(OPERAND_BITS);
	localparam int PROD_BITS = 2 * OPERAND_BITS;
	localparam int RED_CNT_BITS = $clog2(PROD_BITS);
	localparam int PC_BITS = 4;

	// Configuration register indexes.
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS = 1'b1;

	// Microprogram step addresses.
	localparam logic [PC_BITS-1:0] PC_TAKE = 4'd0;
	localparam logic [PC_BITS-1:0] PC_CHECK = 4'd1;
	localparam logic [PC_BITS-1:0] PC_BRED = 4'd2;
	localparam logic [PC_BITS-1:0] PC_INIT = 4'd3;
	localparam logic [PC_BITS-1:0] PC_SQR = 4'd4;
	localparam logic [PC_BITS-1:0] PC_TST = 4'd5;
	localparam logic [PC_BITS-1:0] PC_MUL = 4'd6;
	localparam logic [PC_BITS-1:0] PC_NXT = 4'd7;
	localparam logic [PC_BITS-1:0] PC_DONE = 4'd8;
	localparam logic [PC_BITS-1:0] PC_BAD = 4'd9;

	typedef enum logic [1:0] {OPA_BASE, OPA_ONE, OPA_ACC} opa_sel_t;
	typedef enum logic [1:0] {OPB_ONE, OPB_ACC, OPB_B} opb_sel_t;
	typedef enum logic [1:0] {DST_NONE, DST_B, DST_ACC} dst_sel_t;
	typedef enum logic [2:0] {JC_NONE, JC_ALWAYS, JC_MZERO, JC_EBIT_CLR, JC_CNT_NZ} jcond_t;
	typedef enum logic [1:0] {MM_IDLE, MM_RED, MM_DONE} mm_state_t;

	typedef struct packed {
		logic take;
		logic mul;
		opa_sel_t opa;
		opb_sel_t opb;
		dst_sel_t dst;
		logic cnt_load;
		logic cnt_dec;
		logic emit;
		logic bad;
		jcond_t jc;
		logic [PC_BITS-1:0] target;
	} ucode_word_t;

	typedef struct packed {
		logic in_valid;
		logic m_zero;
		logic e_bit;
		logic cnt_zero;
		logic mul_done;
		logic out_free;
	} seq_status_t;

	typedef struct packed {
		ucode_word_t word;
		logic mul_start;
		logic advance;
	} seq_ctrl_t;

	// The control store: one word per step.
	function automatic ucode_word_t ucode_rom(input logic [PC_BITS-1:0] pc);
		ucode_word_t w;
		w = '{take: 1'b0, mul: 1'b0, opa: OPA_ONE, opb: OPB_ONE, dst: DST_NONE,
			cnt_load: 1'b0, cnt_dec: 1'b0, emit: 1'b0, bad: 1'b0,
			jc: JC_ALWAYS, target: PC_TAKE};
		case (pc)
			PC_TAKE: begin
				w.take = 1'b1;
				w.jc = JC_NONE;
			end
			PC_CHECK: begin
				w.jc = JC_MZERO;
				w.target = PC_BAD;
			end
			PC_BRED: begin
				w.mul = 1'b1;
				w.opa = OPA_BASE;
				w.opb = OPB_ONE;
				w.dst = DST_B;
				w.jc = JC_NONE;
			end
			PC_INIT: begin
				w.mul = 1'b1;
				w.opa = OPA_ONE;
				w.opb = OPB_ONE;
				w.dst = DST_ACC;
				w.cnt_load = 1'b1;
				w.jc = JC_NONE;
			end
			PC_SQR: begin
				w.mul = 1'b1;
				w.opa = OPA_ACC;
				w.opb = OPB_ACC;
				w.dst = DST_ACC;
				w.jc = JC_NONE;
			end
			PC_TST: begin
				w.jc = JC_EBIT_CLR;
				w.target = PC_NXT;
			end
			PC_MUL: begin
				w.mul = 1'b1;
				w.opa = OPA_ACC;
				w.opb = OPB_B;
				w.dst = DST_ACC;
				w.jc = JC_NONE;
			end
			PC_NXT: begin
				w.cnt_dec = 1'b1;
				w.jc = JC_CNT_NZ;
				w.target = PC_SQR;
			end
			PC_DONE: begin
				w.emit = 1'b1;
			end
			PC_BAD: begin
				w.emit = 1'b1;
				w.bad = 1'b1;
			end
			default: begin
				w.jc = JC_ALWAYS;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== design/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: ports, registers and datapath.
//
// Channel  Dir  Signals                          Contents
// s        in   s_tvalid s_tready s_tdata[31:0]  base
// m        out  m_tvalid m_tready m_tdata[31:0]  power_mod, m_tuser[0] bad_modulus
// cfg      in   cfg_we cfg_index cfg_wdata[31:0] 0 exponent, 1 modulus
//
// A zero modulus skips every multiplication and answers with the error flag set.
// Each of the modular multiplications runs in the shared mulmod unit.
// Reset sets exponent and modulus to 1 and puts the sequencer at its fetch step.
// A result waits in the output register while the next base is already taken;
// the sequencer holds at its emit step only while that register is still full.

`include "modular_exponentiation_defines.svh"

module modular_exponentiation
	import mexp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_BITS-1:0] s_tdata,   // [31:0] base
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_BITS-1:0] m_tdata,   // [31:0] power_mod
	output logic [0:0]           m_tuser,   // [0] bad_modulus
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [DATA_BITS-1:0] cfg_wdata
);

	// Configuration registers, held in their low operand bits.
	logic [OPERAND_BITS-1:0] exp_q, mod_q;
	// Working registers: latched base, reduced base, accumulator, bit counter.
	logic [OPERAND_BITS-1:0] base_q, b_q, acc_q;
	logic [CNT_BITS-1:0] cnt_q;
	// Output register.
	logic out_valid_q, out_bad_q;
	logic [OPERAND_BITS-1:0] out_data_q;

	logic [OPERAND_BITS-1:0] op_a, op_b, mm_result;
	logic mm_done;
	seq_status_t status;
	seq_ctrl_t ctrl;
	logic step_ok;

	// Configuration writes land directly; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= OPERAND_BITS'(1);
			mod_q <= OPERAND_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EXPONENT: exp_q <= cfg_wdata[OPERAND_BITS-1:0];
				REG_MODULUS: mod_q <= cfg_wdata[OPERAND_BITS-1:0];
				default: ;
			endcase
		end
	end

	// The input is ready only at the fetch step of the program.
	assign s_tready = ctrl.word.take;
	assign step_ok = ctrl.advance;

	// Operand selection for the shared multiply-reduce unit.
	always_comb begin
		case (ctrl.word.opa)
			OPA_BASE: op_a = base_q;
			OPA_ONE: op_a = OPERAND_BITS'(1);
			OPA_ACC: op_a = acc_q;
			default: op_a = OPERAND_BITS'(1);
		endcase
		case (ctrl.word.opb)
			OPB_ONE: op_b = OPERAND_BITS'(1);
			OPB_ACC: op_b = acc_q;
			OPB_B: op_b = b_q;
			default: op_b = OPERAND_BITS'(1);
		endcase
	end

	mexp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.mul_start),
		.a      (op_a),
		.b      (op_b),
		.m      (mod_q),
		.done   (mm_done),
		.result (mm_result)
	);

	always_comb begin
		status.in_valid = s_tvalid;
		status.m_zero = (mod_q == '0);
		status.e_bit = exp_q[cnt_q];
		status.cnt_zero = (cnt_q == '0);
		status.mul_done = mm_done;
		status.out_free = !out_valid_q || m_tready;
	end

	mexp_sequencer u_sequencer (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// The base is captured on its transfer; results of multiplies land when the step retires.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) base_q <= s_tdata[OPERAND_BITS-1:0];
		if (step_ok && ctrl.word.mul) begin
			case (ctrl.word.dst)
				DST_B: b_q <= mm_result;
				DST_ACC: acc_q <= mm_result;
				default: ;
			endcase
		end
		if (step_ok && ctrl.word.emit) begin
			out_data_q <= ctrl.word.bad ? '0 : acc_q;
			out_bad_q <= ctrl.word.bad;
		end
	end

	// The bit counter walks the exponent from its top bit down to bit zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (step_ok && ctrl.word.cnt_load) begin
			cnt_q <= CNT_BITS'(OPERAND_BITS - 1);
		end else if (step_ok && ctrl.word.cnt_dec) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_ok && ctrl.word.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = DATA_BITS'(out_data_q);
	assign m_tuser = out_bad_q;

	`MEXP_ASSERT_NOW(a_bad_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0,
		"error result carries nonzero data")

endmodule

// ===== design/mexp_mulmod.sv =====
// Multiply then reduce modulo m by shift-subtract, one product bit per cycle.
`include "modular_exponentiation_defines.svh"

module mexp_mulmod
	import mexp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] a,
	input  logic [OPERAND_BITS-1:0] b,
	input  logic [OPERAND_BITS-1:0] m,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] result
);

	localparam logic [RED_CNT_BITS-1:0] RED_LAST = RED_CNT_BITS'(PROD_BITS - 1);

	mm_state_t state_q, state_d;
	logic [PROD_BITS-1:0] prod_q;
	logic [PROD_BITS-1:0] prod_w;
	logic [OPERAND_BITS-1:0] rem_q;
	logic [OPERAND_BITS-1:0] m_q;
	logic [RED_CNT_BITS-1:0] cnt_q;
	logic [OPERAND_BITS:0] trial;
	logic [OPERAND_BITS:0] diff;
	logic load, shift, rem_ok;

	assign prod_w = PROD_BITS'(a) * PROD_BITS'(b);
	assign trial = {rem_q, prod_q[PROD_BITS-1]};
	assign diff = trial - {1'b0, m_q};
	assign rem_ok = rem_q < m_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			MM_IDLE: if (start) state_d = MM_RED;
			MM_RED: if (cnt_q == RED_LAST) state_d = MM_DONE;
			MM_DONE: state_d = MM_IDLE;
			default: state_d = MM_IDLE;
		endcase
	end

	always_comb begin
		load = 1'b0;
		shift = 1'b0;
		done = 1'b0;
		case (state_q)
			MM_IDLE: load = start;
			MM_RED: shift = 1'b1;
			MM_DONE: done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (load) cnt_q <= '0;
			else if (shift) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= prod_w;
			rem_q <= '0;
			m_q <= m;
		end else if (shift) begin
			prod_q <= {prod_q[PROD_BITS-2:0], 1'b0};
			if (trial >= {1'b0, m_q}) rem_q <= diff[OPERAND_BITS-1:0];
			else rem_q <= trial[OPERAND_BITS-1:0];
		end
	end

	assign result = rem_q;

	`MEXP_ASSERT_NOW(a_rem_reduced, clk, arst_n, done && (m_q != '0), rem_ok,
		"remainder not below modulus at completion")
	`MEXP_ASSERT_NOW(a_start_idle, clk, arst_n, start, state_q == MM_IDLE,
		"multiply started while unit busy")

endmodule

// ===== design/mexp_sequencer.sv =====
// Microprogram sequencer: step counter, control store lookup, waits and jumps.
`include "modular_exponentiation_defines.svh"

module mexp_sequencer
	import mexp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output seq_ctrl_t   ctrl
);

	logic [PC_BITS-1:0] pc_q;
	logic issued_q;
	ucode_word_t word;
	logic stall, jump;

	assign word = ucode_rom(pc_q);

	always_comb begin
		stall = (word.take && !status.in_valid) ||
			(word.mul && !status.mul_done) ||
			(word.emit && !status.out_free);
		case (word.jc)
			JC_NONE: jump = 1'b0;
			JC_ALWAYS: jump = 1'b1;
			JC_MZERO: jump = status.m_zero;
			JC_EBIT_CLR: jump = !status.e_bit;
			JC_CNT_NZ: jump = !status.cnt_zero;
			default: jump = 1'b0;
		endcase
		ctrl.word = word;
		ctrl.advance = !stall;
		ctrl.mul_start = word.mul && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= PC_TAKE;
			issued_q <= 1'b0;
		end else begin
			if (ctrl.advance) begin
				pc_q <= jump ? word.target : pc_q + 1'b1;
				issued_q <= 1'b0;
			end else if (ctrl.mul_start) begin
				issued_q <= 1'b1;
			end
		end
	end

	`MEXP_ASSERT_NEXT(a_single_start, clk, arst_n, ctrl.mul_start, !ctrl.mul_start,
		"multiply issued twice for one step")

endmodule

// ===== bench/modular_exponentiation_checker.sv =====
// Stream checker for the modular exponentiation block: predicts every result and compares it.
`timescale 1ns / 100ps

module modular_exponentiation_checker
	import mexp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [DATA_BITS-1:0] s_tdata,   // [31:0] base
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [DATA_BITS-1:0] m_tdata,   // [31:0] power_mod
	input  logic [0:0]           m_tuser,   // [0] bad_modulus
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [DATA_BITS-1:0] cfg_wdata,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic [DATA_BITS-1:0] power_mod;
		logic                 bad_modulus;
	} power_result_t;

	localparam logic [63:0] OPERAND_MASK = (64'd1 << OPERAND_BITS) - 64'd1;

	logic [63:0] exponent_q;
	logic [63:0] modulus_q;
	power_result_t expected_powers[$];

	// Left-to-right square-and-multiply over the full operand width.
	function automatic power_result_t predict_power(input logic [63:0] base,
			input logic [63:0] e, input logic [63:0] m);
		power_result_t r;
		logic [63:0] b;
		logic [63:0] acc;
		int i;
		if (m == 64'd0) begin
			r.power_mod = '0;
			r.bad_modulus = 1'b1;
			return r;
		end
		b = (base & OPERAND_MASK) % m;
		acc = 64'd1 % m;
		for (i = OPERAND_BITS - 1; i >= 0; i--) begin
			acc = (acc * acc) % m;
			if (e[i])
				acc = (acc * b) % m;
		end
		r.power_mod = acc[DATA_BITS-1:0];
		r.bad_modulus = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		power_result_t want;
		power_result_t got;
		if (!arst_n) begin
			exponent_q = 64'd1;
			modulus_q = 64'd1;
			expected_powers.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// Results are retired before new bases are queued, so a stray result
			// can never be matched against an item accepted at the same edge.
			if (m_tvalid && m_tready) begin
				got.power_mod = m_tdata;
				got.bad_modulus = m_tuser[0];
				if (expected_powers.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result power_mod %h bad_modulus %b",
							$realtime, got.power_mod, got.bad_modulus);
				end else begin
					want = expected_powers.pop_front();
					if (got.power_mod !== want.power_mod ||
							got.bad_modulus !== want.bad_modulus) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch power_mod exp %h got %h, bad_modulus exp %b got %b",
								$realtime, want.power_mod, got.power_mod,
								want.bad_modulus, got.bad_modulus);
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_powers.push_back(predict_power({32'd0, s_tdata}, exponent_q, modulus_q));
			if (cfg_we) begin
				case (cfg_index)
					REG_EXPONENT: exponent_q = {32'd0, cfg_wdata} & OPERAND_MASK;
					REG_MODULUS:  modulus_q = {32'd0, cfg_wdata} & OPERAND_MASK;
					default: ;
				endcase
			end
			pending = expected_powers.size();
		end
	end

endmodule

// ===== bench/modular_exponentiation_tb.sv =====
// Testbench top for the modular exponentiation block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module modular_exponentiation_tb;
	import mexp_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [DATA_BITS-1:0] s_tdata = '0;   // [31:0] base
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [DATA_BITS-1:0] m_tdata;        // [31:0] power_mod
	logic [0:0]           m_tuser;        // [0] bad_modulus
	logic                 cfg_we = 1'b0;
	logic                 cfg_index = REG_EXPONENT;
	logic [DATA_BITS-1:0] cfg_wdata = '0;

	int fail_count;
	int pending;

	// Percentages of cycles in which the sender or the receiver holds back.
	int src_idle_pct = 0;
	int sink_idle_pct = 0;

	// The modulus currently programmed; bases are picked around it.
	logic [31:0] cur_modulus = 32'd1;

	// 12 ns period, low half first.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	modular_exponentiation i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	modular_exponentiation_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// The receiver draws a fresh ready decision every cycle, so its stalls fall on
	// every phase of the block's work, including while a result sits in the output.
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Offers one base and returns at the edge where the transfer happened. The
	// ready line is looked at on the falling edge, where it is settled for the
	// coming rising edge, so the handshake does not depend on event order.
	// Valid is only lowered when a gap is drawn, so back-to-back items keep it high.
	task automatic send_base(input logic [31:0] base);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= base;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// Stops the sender and holds off until every queued result has been taken,
	// then leaves the block quiet before anything else happens.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Programs the exponent, then the modulus, on consecutive edges; the block must be idle.
	task automatic write_operands(input logic [31:0] e, input logic [31:0] m);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_EXPONENT;
		cfg_wdata <= e;
		@(posedge clk);
		cfg_index <= REG_MODULUS;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_modulus = m;
	endtask

	initial begin : stimulus
		int phase;
		int blk;
		int k;
		logic [31:0] e;
		logic [31:0] m;
		logic [31:0] b;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 31;
		sink_idle_pct = 71;

		// Registers straight out of reset: exponent 1, modulus 1, so every result is 0.
		send_base(32'hFFFF_FFFF);
		send_base(32'd5);

		// A zero exponent gives 1, even when the base reduces to zero.
		write_operands(32'd0, 32'hFFFF_FFFF);
		send_base(32'd0);
		send_base(32'hFFFF_FFFF);

		// A zero exponent with modulus 1 gives 0.
		write_operands(32'd0, 32'd1);
		send_base(32'd7);

		// A zero modulus raises the error flag whatever the base.
		write_operands(32'hFFFF_FFFF, 32'd0);
		send_base(32'd3);
		send_base(32'hFFFF_FFFF);

		// Largest exponent and modulus: the longest run of multiplications.
		write_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_base(32'hFFFF_FFFE);
		send_base(32'hFFFF_FFFF);
		send_base(32'd2);
		send_base(32'd1);

		// A textbook key pair; bases below, at and above the modulus get reduced first.
		write_operands(32'd65537, 32'd3233);
		send_base(32'd65);
		send_base(32'd3232);
		send_base(32'd3233);
		send_base(32'd3234);

		// Squaring near the top of the range, where the products need all 64 bits.
		write_operands(32'd2, 32'hFFFF_FFFB);
		send_base(32'hFFFF_FFFA);
		send_base(32'h8000_0000);

		// Random part: three idling profiles, each with several operand settings.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 31;
					sink_idle_pct = 71;
				end
				1: begin
					src_idle_pct = 71;
					sink_idle_pct = 31;
				end
				default: begin
					src_idle_pct = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (blk = 0; blk < 5; blk++) begin
				case ($urandom_range(0, 11))
					0: m = 32'd0;
					1: m = 32'd1;
					2: m = 32'hFFFF_FFFF;
					3: m = $urandom_range(2, 255);
					4: m = $urandom | 32'h8000_0000;
					default: m = $urandom;
				endcase
				case ($urandom_range(0, 9))
					0: e = 32'd0;
					1: e = 32'hFFFF_FFFF;
					2: e = 32'd65537;
					3: e = $urandom_range(1, 15);
					default: e = $urandom;
				endcase
				write_operands(e, m);
				for (k = 0; k < 8; k++) begin
					case ($urandom_range(0, 11))
						0: b = 32'd0;
						1: b = 32'hFFFF_FFFF;
						2: b = cur_modulus - 32'd1;
						3: b = cur_modulus;
						4: b = cur_modulus + 32'd1;
						5: b = $urandom_range(0, 255);
						default: b = $urandom;
					endcase
					send_base(b);
				end
			end
		end

		drain_results();
		repeat (100) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// About 137 items come to under 8 ms even at their longest; 60 ms leaves
	// ample room for the idling on both sides.
	initial begin : watchdog
		#60_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
